// ----- rtl/short_long_key_press_detector_unit_macros.svh -----
// Assertion shorthands used by the checker file.
`ifndef SHORT_LONG_KEY_PRESS_DETECTOR_UNIT_MACROS_SVH
`define SHORT_LONG_KEY_PRESS_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SLKP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slkp check failed");

// Next-cycle implication, disabled while in reset
`define SLKP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slkp check failed");

`endif

// ----- rtl/slkpd_pkg.sv -----
`timescale 1ns / 1ps

package slkpd_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam int NUM_KEYS    = 4;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_HOLD = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_HOLD  = 2'd1;

    localparam logic [CFG_WIDTH-1:0] SHORT_HOLD_RESET = 16'd20;
    localparam logic [CFG_WIDTH-1:0] LONG_HOLD_RESET  = 16'd800;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Key event state codes; 6 and 7 are unused
    localparam logic [2:0] ST_IDLE           = 3'd0;
    localparam logic [2:0] ST_PRESS_MOMENT   = 3'd1;
    localparam logic [2:0] ST_PRESSED        = 3'd2;
    localparam logic [2:0] ST_RELEASE_MOMENT = 3'd3;
    localparam logic [2:0] ST_SHORT          = 3'd4;
    localparam logic [2:0] ST_LONG           = 3'd5;

    typedef struct packed {
        logic       action;
        logic       talk_level;
        logic       second_level;
        logic       third_level;
        logic       fourth_level;
        logic [1:0] which_key;
        logic [2:0] new_state;
    } in_t;

    typedef struct packed {
        logic [2:0] talk_state;
        logic [2:0] second_state;
        logic [2:0] third_state;
        logic [2:0] fourth_state;
    } out_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] cnt;
        logic                   lock;
        logic                   armed;
        logic [2:0]             state;
    } key_t;

endpackage

// ----- rtl/slkpd_key_next.sv -----
`timescale 1ns / 1ps

module slkpd_key_next
    import slkpd_pkg::*;
(
    input  key_t                 cur,
    input  logic                 talk_mode,
    input  logic                 tick,
    input  logic                 level,
    input  logic                 wr_hit,
    input  logic [2:0]           new_state,
    input  logic [CFG_WIDTH-1:0] short_hold,
    input  logic [CFG_WIDTH-1:0] long_hold,
    output key_t                 nxt
);

    logic [COUNT_WIDTH-1:0] inc;
    logic                   gt_short;
    logic                   gt_long;

    // Saturate at all ones
    assign inc      = (cur.cnt != {COUNT_WIDTH{1'b1}}) ? cur.cnt + 1'b1 : cur.cnt;
    assign gt_short = CMP_WIDTH'(inc) > CMP_WIDTH'(short_hold);
    assign gt_long  = CMP_WIDTH'(inc) > CMP_WIDTH'(long_hold);

    always_comb
    begin
        nxt = cur;
        if (tick)
        begin
            if (!level)
            begin
                if (!cur.lock)
                begin
                    nxt.cnt = inc;
                    if (talk_mode)
                    begin
                        if (gt_short)
                        begin
                            nxt.cnt   = '0;
                            nxt.lock  = 1'b1;
                            nxt.state = ST_PRESS_MOMENT;
                        end
                    end
                    else
                    begin
                        if (gt_short)
                            nxt.armed = 1'b1;
                        if (gt_long)
                        begin
                            nxt.armed = 1'b0;
                            nxt.cnt   = '0;
                            nxt.lock  = 1'b1;
                            nxt.state = ST_LONG;
                        end
                    end
                end
            end
            else
            begin
                nxt.lock = 1'b0;
                nxt.cnt  = '0;
                if (talk_mode)
                begin
                    if (cur.state == ST_PRESSED)
                        nxt.state = ST_RELEASE_MOMENT;
                end
                else if (cur.armed)
                begin
                    nxt.armed = 1'b0;
                    nxt.state = ST_SHORT;
                end
            end
        end
        else if (wr_hit)
        begin
            nxt.state = new_state;
        end
    end

endmodule

// ----- rtl/slkpd_key_bank.sv -----
`timescale 1ns / 1ps

module slkpd_key_bank
    import slkpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  in_t                  item,
    input  logic [CFG_WIDTH-1:0] short_hold,
    input  logic [CFG_WIDTH-1:0] long_hold,
    output out_t                 result
);

    key_t                key_reg  [NUM_KEYS];
    key_t                key_next [NUM_KEYS];
    logic [NUM_KEYS-1:0] levels;
    logic                tick;
    logic                wr_ok;

    assign levels = {item.fourth_level, item.third_level, item.second_level, item.talk_level};
    assign tick   = (item.action == ACT_TICK);
    assign wr_ok  = (item.action == ACT_WRITE) && (item.new_state <= ST_LONG);

    for (genvar i = 0; i < NUM_KEYS; i++)
    begin : g_key
        slkpd_key_next u_next (
            .cur        (key_reg[i]),
            .talk_mode  (i == 0),
            .tick       (tick),
            .level      (levels[i]),
            .wr_hit     (wr_ok && (item.which_key == 2'(i))),
            .new_state  (item.new_state),
            .short_hold (short_hold),
            .long_hold  (long_hold),
            .nxt        (key_next[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                key_reg[i].cnt   <= '0;
                key_reg[i].lock  <= 1'b0;
                key_reg[i].armed <= 1'b0;
                key_reg[i].state <= ST_IDLE;
            end
        end
        else if (fire)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
                key_reg[i] <= key_next[i];
        end
    end

    assign result.talk_state   = key_next[0].state;
    assign result.second_state = key_next[1].state;
    assign result.third_state  = key_next[2].state;
    assign result.fourth_state = key_next[3].state;

endmodule

// ----- rtl/short_long_key_press_detector_unit.sv -----
`timescale 1ns / 1ps
// Debounces one push-to-talk key and three function keys (active low) and
// reports one result of all four key event states for every request. A
// request is either a timer tick carrying the pin levels or a software write
// of one key's state. Throughput is one request per cycle unless the output
// stalls; a request passes the input register, the key state update and the
// result register. The input side stalls only while the result register
// holds a result not yet taken. The user must write thresholds on the cfg
// port while the block is idle (unenforced); cfg_ready is always high.

module short_long_key_press_detector_unit
    import slkpd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  in_t                        in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output out_t                       out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data
);

    logic                 in_valid_reg;
    in_t                  in_reg;
    logic                 out_valid_reg;
    out_t                 out_reg;
    logic [CFG_WIDTH-1:0] short_hold_reg;
    logic [CFG_WIDTH-1:0] long_hold_reg;
    logic                 advance;
    logic                 fire;
    out_t                 result;

    assign advance   = !out_valid_reg || out_ready;
    assign fire      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_hold_reg <= SHORT_HOLD_RESET;
            long_hold_reg  <= LONG_HOLD_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_SHORT_HOLD)
                short_hold_reg <= cfg_data;
            else if (cfg_index == REG_LONG_HOLD)
                long_hold_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_reg <= in_data;
        if (fire)
            out_reg <= result;
    end

    slkpd_key_bank u_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (in_reg),
        .short_hold (short_hold_reg),
        .long_hold  (long_hold_reg),
        .result     (result)
    );

endmodule

// ----- rtl/slkpd_checker.sv -----
`timescale 1ns / 1ps
`include "short_long_key_press_detector_unit_macros.svh"

module slkpd_checker
    import slkpd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // Hold a stalled result
    `SLKP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    // An empty result stage never blocks the input side
    `SLKP_ASSERT_IMPLY(a_in_free, clk, rst_n, !out_valid, in_ready)
    // Unused state codes never reach the output
    `SLKP_ASSERT_IMPLY(a_codes_ok, clk, rst_n, out_valid, (out_data.talk_state <= ST_LONG) && (out_data.second_state <= ST_LONG) && (out_data.third_state <= ST_LONG) && (out_data.fourth_state <= ST_LONG))
    // Hold a waiting request until it is taken
    `SLKP_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)

endmodule

bind short_long_key_press_detector_unit slkpd_checker u_slkpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- verif/short_long_key_press_detector_unit_tb.sv -----
`timescale 1ns / 1ps

module short_long_key_press_detector_unit_tb;
    import slkpd_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [1:0] KEY_TALK   = 2'd0;

    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 5000;

    class key_scoreboard;
        logic [CFG_WIDTH-1:0]   short_ticks;
        logic [CFG_WIDTH-1:0]   long_ticks;
        logic [COUNT_WIDTH-1:0] hold_cnt[NUM_KEYS];
        bit                     locked[NUM_KEYS];
        bit                     armed[NUM_KEYS];
        logic [2:0]             key_state[NUM_KEYS];
        out_t                   expected_states[$];
        int                     error_count;
        string                  field_names[NUM_KEYS] =
            '{"talk_state", "second_state", "third_state", "fourth_state"};

        function new();
            short_ticks = SHORT_HOLD_RESET;
            long_ticks  = LONG_HOLD_RESET;
            error_count = 0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                hold_cnt[k]  = '0;
                locked[k]    = 1'b0;
                armed[k]     = 1'b0;
                key_state[k] = ST_IDLE;
            end
        endfunction

        function void write_threshold(logic [CFG_INDEX_WIDTH-1:0] idx,
                                      logic [CFG_WIDTH-1:0] value);
            if (idx == REG_SHORT_HOLD)
                short_ticks = value;
            else if (idx == REG_LONG_HOLD)
                long_ticks = value;
        endfunction

        // Key 0 is the talk key; the others are function keys
        function void tick_key(int k, logic level);
            if (level == 1'b0)
            begin
                if (!locked[k])
                begin
                    if (hold_cnt[k] != '1)
                        hold_cnt[k] = hold_cnt[k] + 1'b1;
                    if (k == 0)
                    begin
                        if (hold_cnt[k] > short_ticks)
                        begin
                            hold_cnt[k]  = '0;
                            locked[k]    = 1'b1;
                            key_state[k] = ST_PRESS_MOMENT;
                        end
                    end
                    else
                    begin
                        if (hold_cnt[k] > short_ticks)
                            armed[k] = 1'b1;
                        if (hold_cnt[k] > long_ticks)
                        begin
                            armed[k]     = 1'b0;
                            hold_cnt[k]  = '0;
                            locked[k]    = 1'b1;
                            key_state[k] = ST_LONG;
                        end
                    end
                end
            end
            else
            begin
                locked[k]   = 1'b0;
                hold_cnt[k] = '0;
                if (k == 0)
                begin
                    if (key_state[k] == ST_PRESSED)
                        key_state[k] = ST_RELEASE_MOMENT;
                end
                else if (armed[k])
                begin
                    armed[k]     = 1'b0;
                    key_state[k] = ST_SHORT;
                end
            end
        endfunction

        function void note_request(in_t req);
            out_t states;
            if (req.action == ACT_TICK)
            begin
                tick_key(0, req.talk_level);
                tick_key(1, req.second_level);
                tick_key(2, req.third_level);
                tick_key(3, req.fourth_level);
            end
            else if (req.new_state <= ST_LONG)
                key_state[req.which_key] = req.new_state;
            states.talk_state   = key_state[0];
            states.second_state = key_state[1];
            states.third_state  = key_state[2];
            states.fourth_state = key_state[3];
            expected_states.push_back(states);
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_states.size() == 0)
            begin
                $display("%0t: result %h arrived with none expected", $time, got);
                error_count++;
                return;
            end
            want = expected_states.pop_front();
            for (int f = 0; f < NUM_KEYS; f++)
                if (got[$bits(out_t)-1-3*f -: 3] !== want[$bits(out_t)-1-3*f -: 3])
                begin
                    $display("%0t: wrong %s, expected %0d, actual %0d", $time, field_names[f],
                             want[$bits(out_t)-1-3*f -: 3], got[$bits(out_t)-1-3*f -: 3]);
                    error_count++;
                end
        endfunction
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    in_t                        in_data   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    out_t                       out_data;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]       cfg_data  = '0;

    key_scoreboard sb = new();

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   stall_cycles  = 0;
    logic key_level[NUM_KEYS] = '{1'b1, 1'b1, 1'b1, 1'b1};
    int   run_left[NUM_KEYS]  = '{0, 0, 0, 0};

    short_long_key_press_detector_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic in_t make_tick(logic [3:0] levels);
        in_t req;
        req              = in_t'($urandom_range(0, (1 << $bits(in_t)) - 1));
        req.action       = ACT_TICK;
        req.talk_level   = levels[3];
        req.second_level = levels[2];
        req.third_level  = levels[1];
        req.fourth_level = levels[0];
        return req;
    endfunction

    function automatic in_t make_write(logic [1:0] key, logic [2:0] code);
        in_t req;
        req           = in_t'($urandom_range(0, (1 << $bits(in_t)) - 1));
        req.action    = ACT_WRITE;
        req.which_key = key;
        req.new_state = code;
        return req;
    endfunction

    // Keys follow hold runs sized around the thresholds, with short bounces between
    function automatic in_t next_random_request();
        in_t req;
        int  span;
        req = in_t'($urandom_range(0, (1 << $bits(in_t)) - 1));
        if ($urandom_range(0, 99) < 15)
        begin
            req.action = ACT_WRITE;
            if ($urandom_range(0, 2) == 0)
            begin
                req.which_key = KEY_TALK;
                req.new_state = ST_PRESSED;
            end
            return req;
        end
        span = ((sb.long_ticks > sb.short_ticks) ? sb.long_ticks : sb.short_ticks) + 4;
        if (span > 40)
            span = 40;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (run_left[k] == 0)
            begin
                key_level[k] = ~key_level[k];
                run_left[k]  = key_level[k] ? $urandom_range(1, 6) : $urandom_range(1, span);
            end
            run_left[k]--;
        end
        req.action       = ACT_TICK;
        req.talk_level   = key_level[0];
        req.second_level = key_level[1];
        req.third_level  = key_level[2];
        req.fourth_level = key_level[3];
        return req;
    endfunction

    task automatic drive_request(in_t req);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(req);
        @(negedge clk);
    endtask

    // Hold off new requests until every expected result has arrived
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.expected_states.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_threshold(idx, value);
        @(negedge clk);
    endtask

    task automatic set_thresholds(logic [CFG_WIDTH-1:0] short_val, logic [CFG_WIDTH-1:0] long_val);
        write_reg(REG_SHORT_HOLD, short_val);
        write_reg(REG_LONG_HOLD, long_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count, int sender_idle, int receiver_idle);
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2 || $urandom_range(0, 99) == 0)
                wait_idle();
            drive_request(next_random_request());
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 87;

        // Every state code, the unused ones included, at the reset thresholds
        for (int s = 0; s < 8; s++)
            drive_request(make_write(s[1:0], s[2:0]));
        drive_request(make_tick(4'b0000));
        drive_request(make_tick(4'b0101));
        drive_request(make_tick(4'b1111));
        wait_idle();

        // Press moment, long press, release moment and short press
        set_thresholds(16'd1, 16'd3);
        repeat (4) drive_request(make_tick(4'b0000));
        drive_request(make_tick(4'b1111));
        drive_request(make_write(KEY_TALK, ST_PRESSED));
        drive_request(make_tick(4'b1111));
        repeat (2) drive_request(make_tick(4'b0000));
        drive_request(make_tick(4'b1111));
        wait_idle();

        write_reg(REG_SPARE_2, 16'($urandom));
        write_reg(REG_SPARE_3, 16'($urandom));
        set_thresholds(16'd0, 16'd0);
        run_random(80, 32, 87);
        set_thresholds(16'd3, 16'd9);
        run_random(180, 32, 87);
        set_thresholds(16'd65534, 16'd65534);
        run_random(60, 87, 32);
        // Short not below long: only long presses on the function keys
        set_thresholds(16'd7, 16'd4);
        run_random(120, 87, 32);
        set_thresholds(16'd2, 16'd6);
        run_random(160, 0, 0);

        if (sb.error_count == 0 && sb.expected_states.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
